/* rtl/core/rlfs_pkg.sv */
// Shared types, constants and the note colour table of the RGB fade/slew controller.
package rlfs_pkg;

  localparam int unsigned NUM_LANES  = 3;   // red, green, blue
  localparam int unsigned NUM_NOTES  = 12;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned DIV_STEPS  = LEVEL_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Operation codes of a request
  localparam logic [1:0] OP_DIM    = 2'd0;
  localparam logic [1:0] OP_NOTE   = 2'd1;
  localparam logic [1:0] OP_DIRECT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_PERIOD      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_IN_INTERVAL = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FADE_PERIOD_RST      = 10'd10;
  localparam logic [CFG_DATA_W-1:0] FADE_IN_INTERVAL_RST = 10'd5;

  // Colour weights per note, packed {red, green, blue}, 2 bits each
  localparam logic [5:0] WEIGHT_TAB [NUM_NOTES] = '{
    6'b10_00_00, 6'b10_01_00, 6'b10_10_00, 6'b01_10_00,
    6'b00_10_00, 6'b00_10_01, 6'b00_10_10, 6'b00_01_10,
    6'b00_00_10, 6'b01_00_10, 6'b10_00_10, 6'b10_00_01
  };

  typedef enum logic [1:0] {
    LANE_NOP,
    LANE_SLEW,
    LANE_DIM
  } lane_cmd_e;

  typedef struct packed {
    logic                  start;
    lane_cmd_e             cmd;
    logic                  slew_en;
    logic [CFG_DATA_W-1:0] divisor;
  } lane_ctl_t;

  // Weight (0..2) times a 7-bit volume, at most 254
  function automatic logic [LEVEL_W-1:0] note_goal(input logic [1:0] weight,
                                                   input logic [6:0] vol);
    logic [LEVEL_W-1:0] res;
    unique case (weight)
      2'd1:    res = {1'b0, vol};
      2'd2:    res = {vol, 1'b0};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/rlfs_ifs.sv */
// Request, response and configuration channel interfaces.
interface rlfs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [3:0]  note_index;
  logic [6:0]  volume;
  logic [7:0]  red_target;
  logic [7:0]  green_target;
  logic [7:0]  blue_target;

  modport source (output valid, op, now_ms, note_index, volume, red_target, green_target,
                  blue_target, input ready);
  modport sink (input valid, op, now_ms, note_index, volume, red_target, green_target,
                blue_target, output ready);
endinterface

interface rlfs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_duty;
  logic [7:0] green_duty;
  logic [7:0] blue_duty;
  logic       written;

  modport source (output valid, red_duty, green_duty, blue_duty, written, input ready);
  modport sink (input valid, red_duty, green_duty, blue_duty, written, output ready);
endinterface

interface rlfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [9:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/core/rlfs_lane.sv */
// One colour channel: level and goal registers, slew step and iterative dim divider.
module rlfs_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rlfs_pkg::lane_ctl_t          ctl_i,
  input  logic [rlfs_pkg::LEVEL_W-1:0] goal_i,
  output logic [rlfs_pkg::LEVEL_W-1:0] level_o,
  output logic                         done_o
);
  import rlfs_pkg::*;

  logic [LEVEL_W-1:0]    level_q, level_d;
  logic [LEVEL_W-1:0]    goal_q, goal_d;
  logic [LEVEL_W-1:0]    dvd_q, dvd_d;
  logic [LEVEL_W-1:0]    quo_q, quo_d;
  logic [CFG_DATA_W-1:0] rem_q, rem_d;
  logic [CFG_DATA_W-1:0] div_q, div_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [CFG_DATA_W:0]   trial;
  logic [CFG_DATA_W:0]   diff;
  logic                  ge;
  logic [LEVEL_W-1:0]    quo_next;
  logic [LEVEL_W-1:0]    slewed;
  logic [LEVEL_W-1:0]    dimmed;

  // One restoring divide step per cycle
  always_comb begin
    trial    = {rem_q, dvd_q[LEVEL_W-1]};
    ge       = (trial >= {1'b0, div_q});
    diff     = trial - {1'b0, div_q};
    quo_next = {quo_q[LEVEL_W-2:0], ge};
  end

  // Move one count toward the new goal
  always_comb begin
    if (goal_i > level_q) begin
      slewed = level_q + LEVEL_W'(1);
    end else if (goal_i < level_q) begin
      slewed = level_q - LEVEL_W'(1);
    end else begin
      slewed = level_q;
    end
  end

  // Drop by the quotient, clamp at zero
  always_comb begin
    if (level_q == '0 || quo_next >= level_q) begin
      dimmed = '0;
    end else begin
      dimmed = level_q - quo_next;
    end
  end

  always_comb begin
    level_d = level_q;
    goal_d  = goal_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      dvd_d = {dvd_q[LEVEL_W-2:0], 1'b0};
      quo_d = quo_next;
      rem_d = ge ? diff[CFG_DATA_W-1:0] : trial[CFG_DATA_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        level_d = dimmed;
        busy_d  = 1'b0;
        done_d  = 1'b1;
      end
    end else if (ctl_i.start) begin
      unique case (ctl_i.cmd)
        LANE_SLEW: begin
          goal_d = goal_i;
          if (ctl_i.slew_en) begin
            level_d = slewed;
          end
        end
        LANE_DIM: begin
          dvd_d  = goal_q;
          quo_d  = '0;
          rem_d  = '0;
          div_d  = ctl_i.divisor;
          cnt_d  = DIV_CNT_W'(DIV_STEPS);
          busy_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      goal_q  <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      level_q <= level_d;
      goal_q  <= goal_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign level_o = level_q;
  assign done_o  = done_q;

endmodule

/* rtl/core/rlfs_merge.sv */
// Output stage: gathers the three lane levels into one registered response.
module rlfs_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              push_i,
  input  logic [rlfs_pkg::NUM_LANES-1:0][rlfs_pkg::LEVEL_W-1:0] duty_i,
  input  logic                                              written_i,
  output logic                                              ready_o,
  rlfs_rsp_if.source                                        rsp_o
);
  import rlfs_pkg::*;

  logic                              valid_q, valid_d;
  logic [NUM_LANES-1:0][LEVEL_W-1:0] duty_q;
  logic                              written_q;

  assign ready_o = !valid_q || rsp_o.ready;

  // Hold until the receiver takes the response
  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      duty_q    <= duty_i;
      written_q <= written_i;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.red_duty   = duty_q[0];
  assign rsp_o.green_duty = duty_q[1];
  assign rsp_o.blue_duty  = duty_q[2];
  assign rsp_o.written    = written_q;

endmodule

/* rtl/core/rgb_led_fade_slew_controller_core.sv */
// Top level of the RGB LED fade/slew controller: control, timers, lanes and output stage.
//
// Usage:
//   req_i carries one request per event: op (dim, note, direct), a wrapping millisecond
//   timestamp and the note or direct target fields. rsp_o returns exactly one response
//   per request: the three duty levels after the request and a written flag.
//   cfg_i writes fade_period (index 0) and fade_in_interval (index 1); it is always
//   ready and must only be used while no request is in flight.
// Sequencing:
//   Note, direct, unused-op and not-yet-due dim requests go from acceptance through the
//   push state into the registered response. A due dim request first runs the three
//   lane dividers, one quotient bit per cycle, then pushes. One request is in flight at
//   a time: the next is accepted only after the last response was pushed.
// Reset:
//   Levels, goals and both step timestamps clear to zero; fade_period resets to 10 and
//   fade_in_interval to 5. No response is pending after reset.
// Stall:
//   A response waits in the output register while rsp_o.ready is low; one more request
//   is still accepted and processed, then req_i.ready stays low until the slot frees.
module rgb_led_fade_slew_controller_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlfs_req_if.sink   req_i,
  rlfs_rsp_if.source rsp_o,
  rlfs_cfg_if.sink   cfg_i
);
  import rlfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [CFG_DATA_W-1:0]             fade_period_q, fade_period_d;
  logic [CFG_DATA_W-1:0]             fade_in_q, fade_in_d;
  logic [TIME_W-1:0]                 last_dim_q, last_dim_d;
  logic [TIME_W-1:0]                 last_slew_q, last_slew_d;
  logic                              written_q, written_d;

  logic                              accept;
  logic                              dim_due;
  logic                              slew_due;
  logic [TIME_W-1:0]                 dim_gap;
  logic [TIME_W-1:0]                 slew_gap;
  logic [5:0]                        weights;
  logic [NUM_LANES-1:0][LEVEL_W-1:0] goal;
  logic [NUM_LANES-1:0][LEVEL_W-1:0] lane_level;
  logic [NUM_LANES-1:0]              lane_done;
  lane_ctl_t                         lane_ctl;
  logic                              push;
  logic                              push_ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Wrapping gaps since the last dim and slew steps
  always_comb begin
    dim_gap  = req_i.now_ms - last_dim_q;
    slew_gap = req_i.now_ms - last_slew_q;
    dim_due  = dim_gap > {{(TIME_W-CFG_DATA_W){1'b0}}, fade_period_q};
    slew_due = slew_gap > {{(TIME_W-CFG_DATA_W){1'b0}}, fade_in_q};
  end

  // Goals per lane from the note table or the direct fields
  always_comb begin
    weights = (req_i.note_index < 4'(NUM_NOTES)) ? WEIGHT_TAB[req_i.note_index] : '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      goal[l] = note_goal(weights[2*(NUM_LANES-1-l) +: 2], req_i.volume);
    end
    if (req_i.op == OP_DIRECT) begin
      goal[0] = req_i.red_target;
      goal[1] = req_i.green_target;
      goal[2] = req_i.blue_target;
    end
  end

  // Issue the lane command for the accepted request
  always_comb begin
    lane_ctl.start   = accept;
    lane_ctl.cmd     = LANE_NOP;
    lane_ctl.slew_en = slew_due;
    lane_ctl.divisor = (fade_period_q == '0) ? CFG_DATA_W'(1) : fade_period_q;
    if (req_i.op == OP_DIM && dim_due) begin
      lane_ctl.cmd = LANE_DIM;
    end else if (req_i.op == OP_NOTE || req_i.op == OP_DIRECT) begin
      lane_ctl.cmd = LANE_SLEW;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rlfs_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .goal_i  (goal[l]),
      .level_o (lane_level[l]),
      .done_o  (lane_done[l])
    );
  end

  assign push = (state_q == ST_PUSH) && push_ready;

  rlfs_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .duty_i    (lane_level),
    .written_i (written_q),
    .ready_o   (push_ready),
    .rsp_o     (rsp_o)
  );

  // Sequence a request: accept, optional divide, push the response
  always_comb begin
    state_d     = state_q;
    written_d   = written_q;
    last_dim_d  = last_dim_q;
    last_slew_d = last_slew_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d   = ST_PUSH;
          written_d = 1'b0;
          if (req_i.op == OP_DIM) begin
            if (dim_due) begin
              state_d    = ST_DIV;
              written_d  = 1'b1;
              last_dim_d = req_i.now_ms;
            end
          end else if (req_i.op == OP_NOTE || req_i.op == OP_DIRECT) begin
            written_d = 1'b1;
            if (slew_due) begin
              last_slew_d = req_i.now_ms;
            end
          end
        end
      end
      ST_DIV: begin
        if (lane_done[0]) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Write configuration registers
  always_comb begin
    fade_period_d = fade_period_q;
    fade_in_d     = fade_in_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.addr)
        REG_FADE_PERIOD:      fade_period_d = cfg_i.data;
        REG_FADE_IN_INTERVAL: fade_in_d     = cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      written_q     <= 1'b0;
      last_dim_q    <= '0;
      last_slew_q   <= '0;
      fade_period_q <= FADE_PERIOD_RST;
      fade_in_q     <= FADE_IN_INTERVAL_RST;
    end else begin
      state_q       <= state_d;
      written_q     <= written_d;
      last_dim_q    <= last_dim_d;
      last_slew_q   <= last_slew_d;
      fade_period_q <= fade_period_d;
      fade_in_q     <= fade_in_d;
    end
  end

  // Lanes report completion only during a dim divide
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (state_q == ST_DIV))
    else $error("lane finished outside of a dim divide");

  // All lanes finish together
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (&lane_done))
    else $error("lane dividers out of step");

  // Levels hold while no request is in flight
  a_levels_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !accept) |=> $stable(lane_level))
    else $error("levels changed while idle");

  // A push always leaves a response pending
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> rsp_o.valid)
    else $error("pushed response not presented");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the RGB LED fade/slew controller core.
module tb_top;
  import rlfs_pkg::*;

  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam int unsigned LIMIT_CYCLES     = 1000000;
  localparam int unsigned LONG_HOLD_AT     = 250;
  localparam int unsigned LONG_HOLD_CYCLES = 250;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [3:0]  note_index;
    logic [6:0]  volume;
    logic [7:0]  red_target;
    logic [7:0]  green_target;
    logic [7:0]  blue_target;
  } led_req_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic       written;
  } duty_t;

  logic clk_i;
  logic rst_ni;

  rlfs_req_if req_if ();
  rlfs_rsp_if rsp_if ();
  rlfs_cfg_if cfg_if ();

  rgb_led_fade_slew_controller_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the block state: lane 0 red, 1 green, 2 blue
  logic [7:0]  lvl [3];
  logic [7:0]  goal [3];
  logic [31:0] dim_stamp;
  logic [31:0] slew_stamp;
  logic [CFG_DATA_W-1:0] cfg_period;
  logic [CFG_DATA_W-1:0] cfg_interval;

  led_req_t    pend_q [$];
  duty_t       duty_q [$];
  int unsigned queued_total, rsp_count, fail_cnt, cycle_cnt;
  int unsigned dim_taken_cnt, unused_cnt, setting_cnt;
  int unsigned req_gap, rsp_gap, hold_cnt;
  logic        steady, long_hold_done;
  logic        req_fire, rsp_fire;
  logic [31:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Colour weights per note, {red, green, blue}; zero beyond the table
  function automatic logic [5:0] note_weights(input logic [3:0] note);
    logic [5:0] w;
    case (note)
      4'd0:    w = {2'd2, 2'd0, 2'd0};
      4'd1:    w = {2'd2, 2'd1, 2'd0};
      4'd2:    w = {2'd2, 2'd2, 2'd0};
      4'd3:    w = {2'd1, 2'd2, 2'd0};
      4'd4:    w = {2'd0, 2'd2, 2'd0};
      4'd5:    w = {2'd0, 2'd2, 2'd1};
      4'd6:    w = {2'd0, 2'd2, 2'd2};
      4'd7:    w = {2'd0, 2'd1, 2'd2};
      4'd8:    w = {2'd0, 2'd0, 2'd2};
      4'd9:    w = {2'd1, 2'd0, 2'd2};
      4'd10:   w = {2'd2, 2'd0, 2'd2};
      4'd11:   w = {2'd2, 2'd0, 2'd1};
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] dim_lane(input logic [7:0] level, input logic [9:0] dec);
    if (level == 8'd0 || dec >= {2'd0, level}) return 8'd0;
    return level - dec[7:0];
  endfunction

  function automatic logic [7:0] slew_lane(input logic [7:0] level, input logic [7:0] tgt);
    if (tgt > level) return level + 8'd1;
    if (tgt < level) return level - 8'd1;
    return level;
  endfunction

  // Apply one request to the mirrored state and return the duties it should report
  function automatic duty_t advance_leds(input led_req_t rq);
    duty_t            res;
    logic [31:0]      gap;
    logic [9:0]       div;
    logic [5:0]       w;
    res.written = 1'b0;
    case (rq.op)
      OP_DIM: begin
        gap = rq.now_ms - dim_stamp;
        if (gap > {22'd0, cfg_period}) begin
          div = (cfg_period == '0) ? 10'd1 : cfg_period;
          dim_stamp = rq.now_ms;
          for (int l = 0; l < 3; l++) lvl[l] = dim_lane(lvl[l], {2'd0, goal[l]} / div);
          res.written = 1'b1;
        end
      end
      OP_NOTE, OP_DIRECT: begin
        if (rq.op == OP_NOTE) begin
          w = note_weights(rq.note_index);
          for (int l = 0; l < 3; l++) goal[l] = {6'd0, w[5-2*l -: 2]} * {1'b0, rq.volume};
        end else begin
          goal[0] = rq.red_target;
          goal[1] = rq.green_target;
          goal[2] = rq.blue_target;
        end
        gap = rq.now_ms - slew_stamp;
        if (gap > {22'd0, cfg_interval}) begin
          slew_stamp = rq.now_ms;
          for (int l = 0; l < 3; l++) lvl[l] = slew_lane(lvl[l], goal[l]);
        end
        res.written = 1'b1;
      end
      default: ;
    endcase
    res.red_duty   = lvl[0];
    res.green_duty = lvl[1];
    res.blue_duty  = lvl[2];
    return res;
  endfunction

  // None in steady mode; else mostly back to back, sometimes a short pause, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Timestamp advance: small steps, steps around both thresholds, jumps and wraps back
  function automatic logic [31:0] next_gap_ms();
    int unsigned r;
    logic [31:0] span;
    r = $urandom_range(0, 99);
    span = (cfg_period > cfg_interval) ? cfg_period : cfg_interval;
    if (r < 35) return $urandom_range(0, 3);
    if (r < 65) return $urandom_range(0, 2 * span + 2);
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return cfg_period;
        1:       return cfg_period + 1;
        2:       return cfg_interval;
        default: return cfg_interval + 1;
      endcase
    end
    if (r < 90) return $urandom_range(0, 40);
    if (r < 95) return $urandom;
    return -$urandom_range(1, 20);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [31:0] now,
                           input logic [3:0] note, input logic [6:0] vol,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pend_q.push_back('{op, now, note, vol, r, g, b});
    queued_total++;
  endtask

  task automatic queue_random();
    int unsigned r;
    logic [1:0]  op;
    logic [3:0]  note;
    logic [6:0]  vol;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_DIM;
    else if (r < 62) op = OP_NOTE;
    else if (r < 95) op = OP_DIRECT;
    else op = OP_UNUSED;
    note = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
    vol = ($urandom_range(0, 7) == 0) ? 7'd127 : $urandom_range(0, 127);
    clock_ms += next_gap_ms();
    queue_req(op, clock_ms, note, vol, pick_level(), pick_level(), pick_level());
  endtask

  // Repeat one colour target k times, each past the slew interval, then queue one to three dims
  task automatic queue_ramp(input int unsigned k);
    logic [1:0] op;
    logic [3:0] note;
    logic [6:0] vol;
    logic [7:0] r, g, b;
    op = $urandom_range(0, 1) ? OP_NOTE : OP_DIRECT;
    note = $urandom_range(0, 11);
    vol = $urandom_range(0, 127);
    r = pick_level();
    g = pick_level();
    b = pick_level();
    repeat (k) begin
      clock_ms += cfg_interval + 1 + $urandom_range(0, 2);
      queue_req(op, clock_ms, note, vol, r, g, b);
    end
    repeat ($urandom_range(1, 3)) begin
      clock_ms += cfg_period + $urandom_range(0, 2);
      queue_req(OP_DIM, clock_ms, note, vol, r, g, b);
    end
  endtask

  // Wait for every queued request to come back, then let the block settle
  task automatic wait_drained();
    while (rsp_count < queued_total) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.addr  = addr;
    cfg_if.data  = data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    if (addr == REG_FADE_PERIOD) cfg_period = data;
    else if (addr == REG_FADE_IN_INTERVAL) cfg_interval = data;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] period,
                           input logic [CFG_DATA_W-1:0] interval,
                           input int unsigned n, input logic stdy);
    int unsigned start;
    wait_drained();
    write_reg(REG_FADE_PERIOD, period);
    write_reg(REG_FADE_IN_INTERVAL, interval);
    setting_cnt++;
    steady = stdy;
    start = queued_total;
    while (queued_total - start < n) begin
      if ($urandom_range(0, 99) < 30) queue_ramp($urandom_range(6, 30));
      else queue_random();
    end
  endtask

  // Request driver: hold an offered request until it is taken
  always @(negedge clk_i) begin : req_drive
    led_req_t rq;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fire) begin
      if (req_gap != 0) begin
        req_if.valid <= 1'b0;
        req_gap--;
      end else if (pend_q.size() != 0) begin
        rq = pend_q.pop_front();
        req_if.op           <= rq.op;
        req_if.now_ms       <= rq.now_ms;
        req_if.note_index   <= rq.note_index;
        req_if.volume       <= rq.volume;
        req_if.red_target   <= rq.red_target;
        req_if.green_target <= rq.green_target;
        req_if.blue_target  <= rq.blue_target;
        req_if.valid        <= 1'b1;
        req_gap = pick_gap();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response sink: random stalls plus one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      rsp_if.ready <= 1'b0;
      hold_cnt--;
    end else if (!long_hold_done && rsp_count >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_fire) rsp_gap = pick_gap();
      if (rsp_gap != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_gap--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check responses, predict on each accepted request
  always @(posedge clk_i) begin : watch
    led_req_t rq;
    duty_t    want;
    req_fire <= rst_ni && req_if.valid === 1'b1 && req_if.ready === 1'b1;
    rsp_fire <= rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      rsp_count++;
      if (duty_q.size() == 0) begin
        $error("response with no request outstanding");
        fail_cnt++;
      end else begin
        want = duty_q.pop_front();
        check_field("red_duty", want.red_duty, rsp_if.red_duty);
        check_field("green_duty", want.green_duty, rsp_if.green_duty);
        check_field("blue_duty", want.blue_duty, rsp_if.blue_duty);
        check_field("written", {7'd0, want.written}, {7'd0, rsp_if.written});
      end
    end
    if (rst_ni && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      rq.op           = req_if.op;
      rq.now_ms       = req_if.now_ms;
      rq.note_index   = req_if.note_index;
      rq.volume       = req_if.volume;
      rq.red_target   = req_if.red_target;
      rq.green_target = req_if.green_target;
      rq.blue_target  = req_if.blue_target;
      want = advance_leds(rq);
      if (rq.op == OP_UNUSED) unused_cnt++;
      if (rq.op == OP_DIM && want.written) dim_taken_cnt++;
      duty_q.push_back(want);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("rgb_led_fade_slew_controller_core verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_DIM;
    req_if.now_ms = '0;
    req_if.note_index = '0;
    req_if.volume = '0;
    req_if.red_target = '0;
    req_if.green_target = '0;
    req_if.blue_target = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = REG_FADE_PERIOD;
    cfg_if.data = '0;
    steady = 1'b0;
    long_hold_done = 1'b0;
    req_fire = 1'b0;
    rsp_fire = 1'b0;
    cfg_period = FADE_PERIOD_RST;
    cfg_interval = FADE_IN_INTERVAL_RST;
    for (int l = 0; l < 3; l++) begin
      lvl[l] = 8'd0;
      goal[l] = 8'd0;
    end
    dim_stamp = '0;
    slew_stamp = '0;
    clock_ms = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests under the reset settings
    queue_req(OP_DIM, 32'd0, 4'd0, 7'd0, 8'd0, 8'd0, 8'd0);          // dim not yet due
    queue_req(OP_DIRECT, 32'd6, 4'd0, 7'd0, 8'd255, 8'd255, 8'd255);
    queue_req(OP_DIRECT, 32'd8, 4'd0, 7'd0, 8'd0, 8'd0, 8'd0);       // slew interval not passed
    queue_req(OP_NOTE, 32'd20, 4'd2, 7'd127, 8'd0, 8'd0, 8'd0);
    queue_req(OP_NOTE, 32'd26, 4'd0, 7'd0, 8'd255, 8'd255, 8'd255);   // silent note
    queue_req(OP_NOTE, 32'd40, 4'd15, 7'd127, 8'd0, 8'd0, 8'd0);     // note beyond the table
    queue_req(OP_NOTE, 32'd50, 4'd12, 7'd64, 8'd0, 8'd0, 8'd0);
    queue_req(OP_UNUSED, 32'd60, 4'd15, 7'd127, 8'd255, 8'd255, 8'd255);
    queue_req(OP_DIM, 32'd10, 4'd0, 7'd0, 8'd0, 8'd0, 8'd0);         // gap equals period
    queue_req(OP_DIM, 32'd11, 4'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    queue_req(OP_DIRECT, 32'hFFFF_FFFF, 4'd0, 7'd0, 8'd255, 8'd0, 8'd128);
    queue_req(OP_DIM, 32'hFFFF_FFFF, 4'd0, 7'd0, 8'd0, 8'd0, 8'd0);
    for (int n = 0; n < 12; n++)
      queue_req(OP_NOTE, 32'h100 + 6 * n, n[3:0], 7'd127 - n[6:0], 8'd0, 8'd0, 8'd0);
    clock_ms = 32'h0000_1000;

    // Random phases over several fade settings, extremes included
    run_phase(10'd10, 10'd5, 120, 1'b0);
    run_phase(10'd1, 10'd0, 160, 1'b1);
    run_phase(10'd0, 10'd0, 120, 1'b0);
    run_phase(10'd1023, 10'd1023, 80, 1'b0);
    run_phase(10'd1000, 10'd1000, 80, 1'b1);
    repeat (3) run_phase($urandom_range(1, 40), $urandom_range(0, 12), 160, 1'b0);
    wait_drained();

    if (duty_q.size() != 0) begin
      $error("%0d expected responses never arrived", duty_q.size());
      fail_cnt++;
    end
    $display("Checked %0d responses over %0d fade settings: %0d dim steps taken,",
             rsp_count, setting_cnt, dim_taken_cnt);
    $display("%0d unused-op requests, %0d mismatches.", unused_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("rgb_led_fade_slew_controller_core verification clean");
    end else begin
      $display("rgb_led_fade_slew_controller_core verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rlfs_pkg.sv
rtl/core/rlfs_ifs.sv
rtl/core/rlfs_lane.sv
rtl/core/rlfs_merge.sv
rtl/core/rgb_led_fade_slew_controller_core.sv
tb/tb_top.sv
